// ----- hdl/cat_reply_stream_parser_top_defines.svh -----
// Assertion macros used by the checker file of the reply parser.
// Both macros sample on the rising edge of clk and are quiet while arst_n is low.
`ifndef CAT_REPLY_STREAM_PARSER_TOP_DEFINES_SVH
`define CAT_REPLY_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CRSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CRSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/crsp_pkg.sv -----
`timescale 1ns / 1ps

package crsp_pkg;

	typedef enum logic [1:0] {
		FAM_FRAME  = 2'd0,
		FAM_SILENT = 2'd1,
		FAM_QUERY  = 2'd2
	} family_t;

	typedef enum logic [1:0] {
		REPLY_ACK    = 2'd0,
		REPLY_NAK    = 2'd1,
		REPLY_IGNORE = 2'd2
	} reply_t;

	typedef enum logic [1:0] {
		CFG_FAMILY    = 2'd0,
		CFG_RIG_ADDR  = 2'd1,
		CFG_BCAST     = 2'd2
	} cfg_index_t;

	// One step's verdict: hit marks that the word produced a result.
	typedef struct packed {
		logic   hit;
		reply_t reply;
	} result_t;

	localparam logic [7:0] PREAMBLE   = 8'hFE;
	localparam logic [7:0] TERMINATOR = 8'hFD;
	localparam logic [7:0] CTRL_ADDR  = 8'hE0;
	localparam logic [7:0] STATUS_OK  = 8'hFB;
	localparam logic [7:0] STATUS_NG  = 8'hFA;
	localparam logic [7:0] QMARK      = 8'h3F;
	localparam logic [7:0] SEMI       = 8'h3B;
	localparam int unsigned MIN_FRAME = 6;
	// Body bytes needed: destination, source and status.
	localparam logic [1:0] MIN_BODY   = 2'(MIN_FRAME - 3);

endpackage

// ----- hdl/crsp_frame.sv -----
`timescale 1ns / 1ps

module crsp_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         rig_addr,
	input  logic [7:0]         broadcast_addr,
	output crsp_pkg::result_t  res
);

	logic       in_frame_q, in_frame_d;
	logic       prev_pre_q, prev_pre_d;
	logic [1:0] count_q, count_d;
	logic [7:0] dest_q, dest_d;
	logic [7:0] src_q, src_d;
	logic [7:0] status_q, status_d;
	crsp_pkg::reply_t verdict;

	always_comb begin
		if (count_q < crsp_pkg::MIN_BODY) begin
			verdict = crsp_pkg::REPLY_IGNORE;
		end else if (dest_q != crsp_pkg::CTRL_ADDR) begin
			verdict = crsp_pkg::REPLY_IGNORE;
		end else if (rig_addr != broadcast_addr && src_q != rig_addr) begin
			verdict = crsp_pkg::REPLY_IGNORE;
		end else if (status_q == crsp_pkg::STATUS_OK) begin
			verdict = crsp_pkg::REPLY_ACK;
		end else if (status_q == crsp_pkg::STATUS_NG) begin
			verdict = crsp_pkg::REPLY_NAK;
		end else begin
			verdict = crsp_pkg::REPLY_IGNORE;
		end
	end

	always_comb begin
		in_frame_d = in_frame_q;
		prev_pre_d = prev_pre_q;
		count_d    = count_q;
		dest_d     = dest_q;
		src_d      = src_q;
		status_d   = status_q;
		res.hit    = 1'b0;
		res.reply  = verdict;
		if (step) begin
			if (!in_frame_q) begin
				// Hunting: an FD here is dropped like any other byte.
				if (rx_byte == crsp_pkg::PREAMBLE && prev_pre_q) begin
					in_frame_d = 1'b1;
					prev_pre_d = 1'b0;
					count_d    = 2'd0;
				end else begin
					prev_pre_d = (rx_byte == crsp_pkg::PREAMBLE);
				end
			end else if (rx_byte == crsp_pkg::TERMINATOR) begin
				res.hit    = 1'b1;
				in_frame_d = 1'b0;
				prev_pre_d = 1'b0;
				count_d    = 2'd0;
			end else begin
				unique case (count_q)
					2'd0: dest_d = rx_byte;
					2'd1: src_d = rx_byte;
					2'd2: status_d = rx_byte;
					default: ;
				endcase
				if (count_q != 2'd3) begin
					count_d = count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_pre_q <= 1'b0;
			count_q    <= 2'd0;
			dest_q     <= 8'd0;
			src_q      <= 8'd0;
			status_q   <= 8'd0;
		end else begin
			in_frame_q <= in_frame_d;
			prev_pre_q <= prev_pre_d;
			count_q    <= count_d;
			dest_q     <= dest_d;
			src_q      <= src_d;
			status_q   <= status_d;
		end
	end

endmodule

// ----- hdl/crsp_query.sv -----
`timescale 1ns / 1ps

module crsp_query (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_byte,
	input  logic               step_poll,
	input  logic [7:0]         rx_byte,
	output crsp_pkg::result_t  res
);

	logic qpend_q, qpend_d;
	logic nak_q, nak_d;

	always_comb begin
		qpend_d   = qpend_q;
		nak_d     = nak_q;
		res.hit   = 1'b0;
		res.reply = crsp_pkg::REPLY_ACK;
		if (step_poll) begin
			// A poll is clean only when no refusal went out since the last one.
			res.hit   = !nak_q;
			res.reply = crsp_pkg::REPLY_ACK;
			nak_d     = 1'b0;
			qpend_d   = 1'b0;
		end else if (step_byte) begin
			if (rx_byte == crsp_pkg::SEMI && qpend_q) begin
				res.hit   = 1'b1;
				res.reply = crsp_pkg::REPLY_NAK;
				qpend_d   = 1'b0;
				nak_d     = 1'b1;
			end else begin
				qpend_d = (rx_byte == crsp_pkg::QMARK);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpend_q <= 1'b0;
			nak_q   <= 1'b0;
		end else begin
			qpend_q <= qpend_d;
			nak_q   <= nak_d;
		end
	end

endmodule

// ----- hdl/cat_reply_stream_parser_top.sv -----
`timescale 1ns / 1ps

// Radio reply classifier. Each input word is one received byte (tuser low) or an
// end-of-chunk poll (tuser high); a word yields at most one reply word. The block
// takes one word per cycle while the output register is drained: a word is held
// in the input register while its verdict is formed, and the verdict is registered
// into the output register when the word advances; s_axis_tready follows
// m_axis_tready combinationally when both registers are full. Configuration is
// to be written only while the stream is idle, which the block does not enforce;
// the frame and query state is kept across family changes.
module cat_reply_stream_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	input  logic       s_axis_tuser,   // [0] req_type (1 = poll)
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [1:0] reply, [7:2] zero
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic [1:0] family_q;
	logic [7:0] rig_addr_q;
	logic [7:0] bcast_q;

	logic       valid_s1;
	logic       poll_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic       out_valid_q;
	logic [1:0] out_reply_q;

	crsp_pkg::result_t frame_res, query_res, sel_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q   <= crsp_pkg::FAM_FRAME;
			rig_addr_q <= 8'd0;
			bcast_q    <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crsp_pkg::CFG_FAMILY:   family_q <= cfg_wdata[1:0];
				crsp_pkg::CFG_RIG_ADDR: rig_addr_q <= cfg_wdata;
				crsp_pkg::CFG_BCAST:    bcast_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			poll_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	crsp_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance && !poll_s1 && family_q == crsp_pkg::FAM_FRAME),
		.rx_byte        (byte_s1),
		.rig_addr       (rig_addr_q),
		.broadcast_addr (bcast_q),
		.res            (frame_res)
	);

	crsp_query u_query (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_byte (advance && !poll_s1 && family_q == crsp_pkg::FAM_QUERY),
		.step_poll (advance && poll_s1 && family_q == crsp_pkg::FAM_QUERY),
		.rx_byte   (byte_s1),
		.res       (query_res)
	);

	always_comb begin
		unique case (family_q)
			crsp_pkg::FAM_FRAME:  sel_res = frame_res;
			crsp_pkg::FAM_QUERY:  sel_res = query_res;
			crsp_pkg::FAM_SILENT: begin
				sel_res.hit   = poll_s1;
				sel_res.reply = crsp_pkg::REPLY_ACK;
			end
			default: begin
				sel_res.hit   = 1'b0;
				sel_res.reply = crsp_pkg::REPLY_IGNORE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= sel_res.hit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_reply_q <= sel_res.reply;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_reply_q};

endmodule

// ----- hdl/crsp_checker.sv -----
`timescale 1ns / 1ps
`include "cat_reply_stream_parser_top_defines.svh"

module crsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	`CRSP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "reply word dropped while stalled")
	`CRSP_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "reply word changed while stalled")
	`CRSP_ASSERT_NOW(a_reply_code, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0 && m_axis_tdata[1:0] != 2'd3, "reply word carries an undefined code")
	`CRSP_ASSERT_NOW(a_in_open, !m_axis_tvalid, s_axis_tready, "input stalled with an empty output register")
	`CRSP_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser), "input word changed while stalled")

endmodule

bind cat_reply_stream_parser_top crsp_checker u_crsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/cat_reply_stream_parser_top_tb.sv -----
`timescale 1ns / 1ps

module cat_reply_stream_parser_top_tb;

	localparam logic [7:0] FAMILY_UNUSED = 8'd3;
	// Quiet time required before a configuration write, so words that give no reply have also left the block.
	localparam int SETTLE_CYCLES = 4;
	localparam int TARGET_WORDS = 2025;

	typedef enum logic [1:0] {
		STEP_WORD,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic                 poll;
		logic [7:0]           rx;
		crsp_pkg::cfg_index_t idx;
		logic [7:0]           val;
	} plan_step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;   // [7:0] rx_byte
	logic       s_axis_tuser = 1'b0;   // [0] req_type (1 = poll)
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [1:0] reply, [7:2] zero
	logic       cfg_we = 1'b0;
	crsp_pkg::cfg_index_t cfg_index = crsp_pkg::CFG_FAMILY;
	logic [7:0] cfg_wdata = 8'd0;

	cat_reply_stream_parser_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stimulus plan and expected replies.
	plan_step_t        word_plan[$];
	crsp_pkg::reply_t  expected_replies[$];
	int         replies_due = 0;
	int         replies_seen = 0;
	int         words_planned = 0;
	int         errors = 0;

	// Rig address the generator last wrote, so frames can be aimed at the current rig.
	logic [7:0] gen_rig = 8'd0;

	// Classifier state, mirrored from the block.
	logic [1:0] fam_now = crsp_pkg::FAM_FRAME;
	logic [7:0] rig_now = 8'd0;
	logic [7:0] bcast_now = 8'd0;
	logic       in_frame = 1'b0;
	logic       prev_fe = 1'b0;
	logic [1:0] body_cnt = 2'd0;
	logic [7:0] dest_b = 8'd0;
	logic [7:0] src_b = 8'd0;
	logic [7:0] status_b = 8'd0;
	logic       q_pending = 1'b0;
	logic       nak_seen = 1'b0;

	task automatic note_mismatch(input string what);
		errors++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic classify_word(input logic poll, input logic [7:0] b,
			output logic hit, output crsp_pkg::reply_t verdict);
		hit = 1'b0;
		verdict = crsp_pkg::REPLY_ACK;
		case (fam_now)
			crsp_pkg::FAM_FRAME: begin
				if (poll) begin
					// A poll leaves the frame state alone.
				end else if (!in_frame) begin
					if (b == crsp_pkg::PREAMBLE && prev_fe) begin
						in_frame = 1'b1;
						prev_fe = 1'b0;
						body_cnt = 2'd0;
					end else begin
						prev_fe = (b == crsp_pkg::PREAMBLE);
					end
				end else if (b == crsp_pkg::TERMINATOR) begin
					hit = 1'b1;
					if (body_cnt < crsp_pkg::MIN_BODY || dest_b != crsp_pkg::CTRL_ADDR)
						verdict = crsp_pkg::REPLY_IGNORE;
					else if (rig_now != bcast_now && src_b != rig_now)
						verdict = crsp_pkg::REPLY_IGNORE;
					else if (status_b == crsp_pkg::STATUS_OK)
						verdict = crsp_pkg::REPLY_ACK;
					else if (status_b == crsp_pkg::STATUS_NG)
						verdict = crsp_pkg::REPLY_NAK;
					else
						verdict = crsp_pkg::REPLY_IGNORE;
					in_frame = 1'b0;
					prev_fe = 1'b0;
					body_cnt = 2'd0;
				end else begin
					case (body_cnt)
						2'd0: dest_b = b;
						2'd1: src_b = b;
						2'd2: status_b = b;
						default: ;
					endcase
					if (body_cnt != 2'd3)
						body_cnt = body_cnt + 2'd1;
				end
			end
			crsp_pkg::FAM_SILENT: begin
				hit = poll;
			end
			crsp_pkg::FAM_QUERY: begin
				if (poll) begin
					hit = !nak_seen;
					nak_seen = 1'b0;
					q_pending = 1'b0;
				end else if (b == crsp_pkg::SEMI && q_pending) begin
					q_pending = 1'b0;
					nak_seen = 1'b1;
					hit = 1'b1;
					verdict = crsp_pkg::REPLY_NAK;
				end else begin
					q_pending = (b == crsp_pkg::QMARK);
				end
			end
			default: ;
		endcase
	endtask

	task automatic add_word(input logic poll, input logic [7:0] b);
		plan_step_t s;
		s.kind = STEP_WORD;
		s.poll = poll;
		s.rx = b;
		s.idx = crsp_pkg::CFG_FAMILY;
		s.val = 8'd0;
		word_plan.push_back(s);
		words_planned++;
	endtask

	task automatic add_cfg(input crsp_pkg::cfg_index_t idx, input logic [7:0] v);
		plan_step_t s;
		s.kind = STEP_CFG;
		s.poll = 1'b0;
		s.rx = 8'd0;
		s.idx = idx;
		s.val = v;
		word_plan.push_back(s);
		if (idx == crsp_pkg::CFG_RIG_ADDR)
			gen_rig = v;
	endtask

	task automatic add_drain();
		plan_step_t s;
		s.kind = STEP_DRAIN;
		s.poll = 1'b0;
		s.rx = 8'd0;
		s.idx = crsp_pkg::CFG_FAMILY;
		s.val = 8'd0;
		word_plan.push_back(s);
	endtask

	// One frame with random content, mostly well formed and aimed at the current rig.
	task automatic add_frame();
		int n;
		logic [7:0] v;
		repeat ($urandom_range(0, 2))
			add_word(1'b0, 8'($urandom));
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		// An extra preamble byte inside the frame is taken as body.
		if ($urandom_range(0, 9) == 0)
			add_word(1'b0, crsp_pkg::PREAMBLE);
		n = ($urandom_range(0, 9) < 8) ? 3 : $urandom_range(0, 5);
		for (int i = 0; i < n; i++) begin
			v = 8'($urandom);
			if (i == 0 && $urandom_range(0, 9) < 8)
				v = crsp_pkg::CTRL_ADDR;
			else if (i == 1 && $urandom_range(0, 9) < 7)
				v = gen_rig;
			else if (i == 2 && $urandom_range(0, 9) < 9)
				v = $urandom_range(0, 1) ? crsp_pkg::STATUS_OK : crsp_pkg::STATUS_NG;
			if (v == crsp_pkg::TERMINATOR)
				v = 8'h00;
			if ($urandom_range(0, 15) == 0)
				add_word(1'b1, 8'($urandom));
			add_word(1'b0, v);
		end
		if ($urandom_range(0, 9) != 0)
			add_word(1'b0, crsp_pkg::TERMINATOR);
	endtask

	task automatic add_text(input int n, input bit with_marks);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (with_marks && r < 30)
				add_word(1'b0, crsp_pkg::QMARK);
			else if (with_marks && r < 55)
				add_word(1'b0, crsp_pkg::SEMI);
			else if (r < 72)
				add_word(1'b1, 8'($urandom));
			else
				add_word(1'b0, 8'($urandom));
		end
	endtask

	// Sender: bursts of words with gaps, configuration only when the block is quiet.
	int gap_left = 0;
	int burst_left = 1;
	int quiet = 0;

	always @(posedge clk or negedge arst_n) begin : drive_words
		logic       nv;
		logic [7:0] ndata;
		logic       nuser;
		logic       nwe;
		crsp_pkg::cfg_index_t nidx;
		logic [7:0] nwd;
		int         ndue;
		logic       hit;
		crsp_pkg::reply_t verdict;
		plan_step_t head;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tuser <= 1'b0;
			cfg_we <= 1'b0;
			cfg_index <= crsp_pkg::CFG_FAMILY;
			cfg_wdata <= 8'd0;
		end else begin
			nv = s_axis_tvalid;
			ndata = s_axis_tdata;
			nuser = s_axis_tuser;
			nwe = 1'b0;
			nidx = cfg_index;
			nwd = cfg_wdata;
			ndue = replies_due;
			if (s_axis_tvalid && s_axis_tready) begin
				classify_word(s_axis_tuser, s_axis_tdata, hit, verdict);
				if (hit) begin
					expected_replies.push_back(verdict);
					ndue++;
				end
				nv = 1'b0;
				quiet = 0;
			end else if (s_axis_tvalid || ndue != replies_seen) begin
				quiet = 0;
			end else if (quiet < 1000) begin
				quiet++;
			end
			if (!nv && word_plan.size() != 0) begin
				head = word_plan[0];
				case (head.kind)
					STEP_WORD: begin
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							nv = 1'b1;
							ndata = head.rx;
							nuser = head.poll;
							void'(word_plan.pop_front());
							if (burst_left > 1) begin
								burst_left--;
							end else if ($urandom_range(0, 15) == 0) begin
								burst_left = 80;
								gap_left = 0;
							end else begin
								burst_left = $urandom_range(1, 24);
								gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
							end
						end
					end
					STEP_CFG: begin
						if (quiet >= SETTLE_CYCLES) begin
							nwe = 1'b1;
							nidx = head.idx;
							nwd = head.val;
							case (head.idx)
								crsp_pkg::CFG_FAMILY: fam_now = head.val[1:0];
								crsp_pkg::CFG_RIG_ADDR: rig_now = head.val;
								crsp_pkg::CFG_BCAST: bcast_now = head.val;
								default: ;
							endcase
							void'(word_plan.pop_front());
						end
					end
					default: begin
						if (ndue == replies_seen)
							void'(word_plan.pop_front());
					end
				endcase
			end
			s_axis_tvalid <= nv;
			s_axis_tdata <= ndata;
			s_axis_tuser <= nuser;
			cfg_we <= nwe;
			cfg_index <= nidx;
			cfg_wdata <= nwd;
			replies_due <= ndue;
		end
	end

	// Receiver: stall pattern in segments, with a long periodic hold-off.
	int rdy_mode = 0;
	int seg_left = 0;
	int hold_left = 0;
	int rx_cycle = 0;

	always @(posedge clk or negedge arst_n) begin : drive_ready
		logic rdy;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (rx_cycle % 1200 == 600) begin
				hold_left = 64;
				rdy = 1'b0;
			end else begin
				if (seg_left == 0) begin
					rdy_mode = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 200);
				end
				seg_left--;
				case (rdy_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = $urandom_range(0, 4) != 0;
					default: rdy = $urandom_range(0, 4) == 0;
				endcase
			end
			m_axis_tready <= rdy;
		end
	end

	always @(posedge clk) begin : check_replies
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_seen >= replies_due) begin
				note_mismatch($sformatf("reply %0d with no word waiting for one",
					m_axis_tdata));
			end else begin
				if (m_axis_tdata !== {6'b0, expected_replies[replies_seen]})
					note_mismatch($sformatf("reply %0d: got %0d, expected %0d",
						replies_seen, m_axis_tdata, expected_replies[replies_seen]));
				replies_seen <= replies_seen + 1;
			end
		end
	end

	initial begin : run_test
		int waited;
		int pick;
		logic [7:0] fam_v;
		logic [7:0] rig_v;
		logic [7:0] bcast_v;

		// Directed part: a source must match once the rig and broadcast differ.
		add_cfg(crsp_pkg::CFG_FAMILY, 8'(crsp_pkg::FAM_FRAME));
		add_cfg(crsp_pkg::CFG_RIG_ADDR, 8'h94);
		add_cfg(crsp_pkg::CFG_BCAST, 8'h00);
		add_word(1'b0, crsp_pkg::TERMINATOR);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::CTRL_ADDR);
		add_word(1'b0, 8'h94);
		add_word(1'b0, crsp_pkg::STATUS_OK);
		add_word(1'b0, crsp_pkg::TERMINATOR);
		// Short frame with a poll inside it.
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, 8'h00);
		add_word(1'b1, 8'h00);
		add_word(1'b0, crsp_pkg::TERMINATOR);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::PREAMBLE);
		add_word(1'b0, crsp_pkg::CTRL_ADDR);
		add_word(1'b0, 8'h94);
		add_word(1'b0, crsp_pkg::STATUS_NG);
		add_word(1'b0, crsp_pkg::TERMINATOR);
		// Refusal, a poll that stays silent after it, then a clean poll.
		add_cfg(crsp_pkg::CFG_FAMILY, 8'(crsp_pkg::FAM_QUERY));
		add_word(1'b0, crsp_pkg::QMARK);
		add_word(1'b0, crsp_pkg::SEMI);
		add_word(1'b1, 8'hFF);
		add_word(1'b1, 8'h00);
		add_cfg(crsp_pkg::CFG_FAMILY, 8'(crsp_pkg::FAM_SILENT));
		add_word(1'b0, 8'hFF);
		add_word(1'b1, 8'h5A);
		add_cfg(crsp_pkg::CFG_FAMILY, FAMILY_UNUSED);
		add_word(1'b1, 8'hA5);

		while (words_planned < TARGET_WORDS) begin
			pick = $urandom_range(0, 19);
			if (pick < 10)
				fam_v = 8'(crsp_pkg::FAM_FRAME);
			else if (pick < 16)
				fam_v = 8'(crsp_pkg::FAM_QUERY);
			else if (pick < 19)
				fam_v = 8'(crsp_pkg::FAM_SILENT);
			else
				fam_v = FAMILY_UNUSED;
			case ($urandom_range(0, 5))
				0: rig_v = 8'h00;
				1: rig_v = 8'hFF;
				default: rig_v = 8'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: bcast_v = rig_v;
				1: bcast_v = 8'hFF;
				2: bcast_v = 8'h00;
				default: bcast_v = 8'($urandom);
			endcase
			add_cfg(crsp_pkg::CFG_FAMILY, fam_v);
			add_cfg(crsp_pkg::CFG_RIG_ADDR, rig_v);
			add_cfg(crsp_pkg::CFG_BCAST, bcast_v);
			if (fam_v == 8'(crsp_pkg::FAM_FRAME)) begin
				repeat ($urandom_range(4, 25)) begin
					add_frame();
					if ($urandom_range(0, 7) == 0)
						add_text($urandom_range(1, 4), 1'b0);
				end
			end else if (fam_v == 8'(crsp_pkg::FAM_QUERY)) begin
				add_text($urandom_range(20, 150), 1'b1);
			end else if (fam_v == 8'(crsp_pkg::FAM_SILENT)) begin
				add_text($urandom_range(10, 60), 1'b0);
			end else begin
				add_text($urandom_range(3, 10), 1'b1);
			end
			if ($urandom_range(0, 2) == 0)
				add_drain();
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (word_plan.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		waited = 0;
		while (replies_seen != replies_due && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (replies_seen != replies_due)
			note_mismatch($sformatf("%0d replies never arrived", replies_due - replies_seen));
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
